// ----- src/bfhs_pkg.sv -----
// Shared types and constants for the back/forward history stacks.
package bfhs_pkg;

  // Default sizes, handed down from the top level
  localparam int STACK_DEPTH_DEF = 128;
  localparam int PAGE_BITS_DEF   = 32;

  // Width of the reported stack depths
  localparam int DEPTH_BITS = 8;

  // Operation codes carried by an item
  typedef enum logic [1:0] {
    FUNC_VISIT = 2'd0,
    FUNC_BACK  = 2'd1,
    FUNC_FWD   = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_VISITED = 3'd0,
    ST_BACK    = 3'd1,
    ST_FWD     = 3'd2,
    ST_NO_PREV = 3'd3,
    ST_NO_NEXT = 3'd4
  } status_t;

  // Per-cycle command to one stack
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_op_t;

endpackage

// ----- src/back_forward_history_stacks_top.sv -----
// Top level of the back/forward history stacks: control, two cell stacks, result buffer.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | in_func, in_page
//   out_    | output    | out_valid / out_stall | out_status, out_current_page,
//           |           |                     | out_current_valid, out_back_depth,
//           |           |                     | out_forward_depth
//
// One item per cycle while in_stall is low: every item is applied to both stacks together, each
// stack shifting its whole row of cells at once, and its result is registered
// in the output register, or in the skid entry while a held result waits. A result held
// by out_stall is kept in the output register; one more item is taken into the skid
// entry, after which in_stall rises until the held result is taken. Reset is synchronous,
// active low, and empties both stacks and clears the current page at once.
module back_forward_history_stacks_top #(
  parameter int STACK_DEPTH = bfhs_pkg::STACK_DEPTH_DEF,
  parameter int PAGE_BITS   = bfhs_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [PAGE_BITS-1:0]            in_page,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_status,
  output logic [PAGE_BITS-1:0]            out_current_page,
  output logic                            out_current_valid,
  output logic [bfhs_pkg::DEPTH_BITS-1:0] out_back_depth,
  output logic [bfhs_pkg::DEPTH_BITS-1:0] out_forward_depth
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int DB    = bfhs_pkg::DEPTH_BITS;
  localparam int RES_W = 3 + PAGE_BITS + 1 + 2 * DB;

  logic                in_acc;
  bfhs_pkg::func_t     func;
  bfhs_pkg::status_t   status;
  bfhs_pkg::stack_op_t back_op;
  bfhs_pkg::stack_op_t fwd_op;

  logic [PAGE_BITS-1:0] cur_id_r;
  logic [PAGE_BITS-1:0] cur_id_nxt;
  logic                 cur_present_r;
  logic                 cur_present_nxt;

  logic [PAGE_BITS-1:0] back_top;
  logic [PAGE_BITS-1:0] fwd_top;
  logic [CNT_W-1:0]     back_cnt;
  logic [CNT_W-1:0]     back_cnt_nxt;
  logic [CNT_W-1:0]     fwd_cnt;
  logic [CNT_W-1:0]     fwd_cnt_nxt;

  logic [CNT_W+DB-1:0]  back_cnt_ext;
  logic [CNT_W+DB-1:0]  fwd_cnt_ext;
  logic [PAGE_BITS-1:0] res_page;
  logic [RES_W-1:0]     res_data;
  logic [RES_W-1:0]     out_data;
  logic                 skid_full;

  assign in_stall = skid_full;
  assign in_acc   = in_valid && !skid_full;
  assign func     = bfhs_pkg::func_t'(in_func);

  // step decode: stack commands, next current page, status
  always_comb begin
    back_op         = '0;
    fwd_op          = '0;
    cur_id_nxt      = cur_id_r;
    cur_present_nxt = cur_present_r;
    status          = bfhs_pkg::ST_NO_NEXT;
    case (func)
      bfhs_pkg::FUNC_VISIT: begin
        back_op.push    = cur_present_r;
        fwd_op.clear    = 1'b1;
        cur_id_nxt      = in_page;
        cur_present_nxt = 1'b1;
        status          = bfhs_pkg::ST_VISITED;
      end
      bfhs_pkg::FUNC_BACK: begin
        if (!cur_present_r || back_cnt == '0) begin
          status = bfhs_pkg::ST_NO_PREV;
        end else begin
          fwd_op.push = 1'b1;
          back_op.pop = 1'b1;
          cur_id_nxt  = back_top;
          status      = bfhs_pkg::ST_BACK;
        end
      end
      bfhs_pkg::FUNC_FWD: begin
        if (fwd_cnt == '0) begin
          status = bfhs_pkg::ST_NO_NEXT;
        end else begin
          back_op.push    = 1'b1;
          fwd_op.pop      = 1'b1;
          cur_id_nxt      = fwd_top;
          cur_present_nxt = 1'b1;
          status          = bfhs_pkg::ST_FWD;
        end
      end
      default: begin
        status = bfhs_pkg::ST_NO_NEXT;
      end
    endcase
    // nothing moves unless an item is taken
    if (!in_acc) begin
      back_op         = '0;
      fwd_op          = '0;
      cur_id_nxt      = cur_id_r;
      cur_present_nxt = cur_present_r;
    end
  end

  // current page
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_id_r      <= '0;
      cur_present_r <= 1'b0;
    end else begin
      cur_id_r      <= cur_id_nxt;
      cur_present_r <= cur_present_nxt;
    end
  end

  // history stacks; both are pushed with the page being left
  bfhs_stack #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (PAGE_BITS),
    .CNT_W (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (back_op),
    .push_data (cur_id_r),
    .top       (back_top),
    .count     (back_cnt),
    .count_nxt (back_cnt_nxt)
  );

  bfhs_stack #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (PAGE_BITS),
    .CNT_W (CNT_W)
  ) u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (fwd_op),
    .push_data (cur_id_r),
    .top       (fwd_top),
    .count     (fwd_cnt),
    .count_nxt (fwd_cnt_nxt)
  );

  // result: state after the step, depths cut to the reported width
  assign back_cnt_ext = {{DB{1'b0}}, back_cnt_nxt};
  assign fwd_cnt_ext  = {{DB{1'b0}}, fwd_cnt_nxt};
  assign res_page     = cur_present_nxt ? cur_id_nxt : '0;
  assign res_data     = {status, res_page, cur_present_nxt,
                         back_cnt_ext[DB-1:0], fwd_cnt_ext[DB-1:0]};

  bfhs_skid #(
    .WIDTH (RES_W)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_acc),
    .wr_data   (res_data),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign {out_status, out_current_page, out_current_valid,
          out_back_depth, out_forward_depth} = out_data;

  // a held skid entry implies a result is on show
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> out_valid)
    else $error("skid entry held with no result on show");

  // a visit always empties the forward history
  a_visit_clears_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func == bfhs_pkg::FUNC_VISIT) |=> (fwd_cnt == '0))
    else $error("forward history not empty after a visit");

  // occupancy never passes the stack depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (back_cnt <= CNT_W'(STACK_DEPTH)) && (fwd_cnt <= CNT_W'(STACK_DEPTH)))
    else $error("stack occupancy beyond its depth");

endmodule

// ----- src/bfhs_cell.sv -----
// One storage cell of a shifting stack: takes from above on push, from below on pop.
module bfhs_cell #(
  parameter int WIDTH = bfhs_pkg::PAGE_BITS_DEF
) (
  input  logic             clk,
  input  logic             shift_dn,
  input  logic             shift_up,
  input  logic [WIDTH-1:0] up_data,
  input  logic [WIDTH-1:0] dn_data,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] q_r;
  logic [WIDTH-1:0] q_nxt;

  // push moves entries one place deeper, pop moves them one place up
  always_comb begin
    q_nxt = q_r;
    if (shift_dn) begin
      q_nxt = up_data;
    end else if (shift_up) begin
      q_nxt = dn_data;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- src/bfhs_stack.sv -----
// Bounded LIFO built as a row of shifting cells, top of stack in cell 0.
module bfhs_stack #(
  parameter int DEPTH = bfhs_pkg::STACK_DEPTH_DEF,
  parameter int WIDTH = bfhs_pkg::PAGE_BITS_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfhs_pkg::stack_op_t  op,
  input  logic [WIDTH-1:0]     push_data,
  output logic [WIDTH-1:0]     top,
  output logic [CNT_W-1:0]     count,
  output logic [CNT_W-1:0]     count_nxt
);

  logic [CNT_W-1:0] count_r;
  logic             full;
  logic             do_push;
  logic             do_pop;
  logic [WIDTH-1:0] cell_q [DEPTH];

  // a push onto a full stack is dropped; a pop of an empty one does nothing
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = op.push && !full;
  assign do_pop  = op.pop && (count_r != '0);

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (op.clear) begin
      count_nxt = '0;
    end else if (do_push) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] up_d;
    logic [WIDTH-1:0] dn_d;

    if (i == 0) begin : g_head
      assign up_d = push_data;
    end else begin : g_body
      assign up_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign dn_d = '0;
    end else begin : g_link
      assign dn_d = cell_q[i+1];
    end

    bfhs_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk      (clk),
      .shift_dn (do_push),
      .shift_up (do_pop),
      .up_data  (up_d),
      .dn_data  (dn_d),
      .q        (cell_q[i])
    );
  end

  assign top   = cell_q[0];
  assign count = count_r;

endmodule

// ----- src/bfhs_skid.sv -----
// Result register with one skid entry so an item is taken while a result waits.
module bfhs_skid #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [WIDTH-1:0] out_data_r;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  logic [WIDTH-1:0] skid_data_r;
  logic             take;
  logic             load_out;
  logic             load_skid;
  logic             move_skid;

  assign take = out_valid_r && !out_stall;

  // steer a new result into the output register or the skid entry
  always_comb begin
    load_out       = 1'b0;
    load_skid      = 1'b0;
    move_skid      = 1'b0;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (take) begin
        move_skid      = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (wr_en) begin
      if (!out_valid_r || take) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (move_skid) begin
      out_data_r <= skid_data_r;
    end else if (load_out) begin
      out_data_r <= wr_data;
    end
    if (load_skid) begin
      skid_data_r <= wr_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- verif/back_forward_history_stacks_top_tb.sv -----
// Testbench for the back/forward history stacks: queue-fed driver, history predictor, checker.
module back_forward_history_stacks_top_tb;

  localparam int DEPTH          = bfhs_pkg::STACK_DEPTH_DEF;
  localparam int PB             = bfhs_pkg::PAGE_BITS_DEF;
  localparam int DB             = bfhs_pkg::DEPTH_BITS;
  localparam int PERIOD         = 10;
  localparam int IDLE_PCT       = 21;
  localparam int HOLD_CYCLES    = 50;
  localparam int HOLD_AT        = 100;
  localparam int QUIET_FROM     = 450;
  localparam int QUIET_TO       = 600;
  localparam int DRAIN_AT       = 500;
  localparam int DEEP_AT        = 150;
  localparam int TOTAL_ITEMS    = 700;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  // One navigation request and the history view it should produce
  typedef struct {
    bfhs_pkg::func_t func;
    logic [PB-1:0]   page;
    bit              drain_first;
  } nav_item_t;

  typedef struct {
    bfhs_pkg::status_t status;
    logic [PB-1:0]     page;
    logic              valid;
    logic [DB-1:0]     back_depth;
    logic [DB-1:0]     fwd_depth;
  } history_view_t;

  logic            clk               = 1'b0;
  logic            rst_n             = 1'b0;
  logic            in_valid          = 1'b0;
  logic            in_stall;
  bfhs_pkg::func_t in_func           = bfhs_pkg::FUNC_VISIT;
  logic [PB-1:0]   in_page           = '0;
  logic            out_valid;
  logic            out_stall         = 1'b0;
  logic [2:0]      out_status;
  logic [PB-1:0]   out_current_page;
  logic            out_current_valid;
  logic [DB-1:0]   out_back_depth;
  logic [DB-1:0]   out_forward_depth;

  nav_item_t     nav_queue[$];
  history_view_t expected_views[$];
  logic          in_taken    = 1'b0;
  int            sent_count  = 0;
  int            recv_count  = 0;
  int            mismatches  = 0;
  int            idle_cycles = 0;
  int            hold_left   = 0;
  bit            hold_done   = 1'b0;
  bit            mark_drain  = 1'b0;

  // Predicted history state
  logic [PB-1:0] back_pages[DEPTH];
  logic [PB-1:0] fwd_pages[DEPTH];
  int            back_used   = 0;
  int            fwd_used    = 0;
  logic [PB-1:0] cur_page    = '0;
  logic          cur_present = 1'b0;

  back_forward_history_stacks_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_current_page  (out_current_page),
    .out_current_valid (out_current_valid),
    .out_back_depth    (out_back_depth),
    .out_forward_depth (out_forward_depth)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Apply one request to the predicted history; pushes onto a full stack are dropped
  function automatic history_view_t step_history(bfhs_pkg::func_t op, logic [PB-1:0] page);
    history_view_t v;
    case (op)
      bfhs_pkg::FUNC_VISIT: begin
        if (cur_present && back_used < DEPTH) begin
          back_pages[back_used] = cur_page;
          back_used++;
        end
        cur_page    = page;
        cur_present = 1'b1;
        fwd_used    = 0;
        v.status    = bfhs_pkg::ST_VISITED;
      end
      bfhs_pkg::FUNC_BACK: begin
        if (!cur_present || back_used == 0) begin
          v.status = bfhs_pkg::ST_NO_PREV;
        end else begin
          if (fwd_used < DEPTH) begin
            fwd_pages[fwd_used] = cur_page;
            fwd_used++;
          end
          back_used--;
          cur_page = back_pages[back_used];
          v.status = bfhs_pkg::ST_BACK;
        end
      end
      bfhs_pkg::FUNC_FWD: begin
        if (fwd_used == 0) begin
          v.status = bfhs_pkg::ST_NO_NEXT;
        end else begin
          if (back_used < DEPTH) begin
            back_pages[back_used] = cur_page;
            back_used++;
          end
          fwd_used--;
          cur_page    = fwd_pages[fwd_used];
          cur_present = 1'b1;
          v.status    = bfhs_pkg::ST_FWD;
        end
      end
      default: begin
        v.status = bfhs_pkg::ST_NO_NEXT;
      end
    endcase
    v.page       = cur_present ? cur_page : '0;
    v.valid      = cur_present;
    v.back_depth = DB'(back_used);
    v.fwd_depth  = DB'(fwd_used);
    return v;
  endfunction

  task automatic queue_item(bfhs_pkg::func_t op, logic [PB-1:0] page);
    nav_item_t item;
    item.func        = op;
    item.page        = page;
    item.drain_first = mark_drain;
    mark_drain       = 1'b0;
    nav_queue.push_back(item);
  endtask

  task automatic queue_burst(bfhs_pkg::func_t op, int n);
    for (int i = 0; i < n; i++) begin
      queue_item(op, PB'($urandom()));
    end
  endtask

  // Driver: new item at the falling edge once the previous one is taken
  always @(negedge clk) begin : drive_nav
    logic      offer;
    bit        quiet;
    nav_item_t item;
    offer = in_valid;
    quiet = (sent_count >= QUIET_FROM && sent_count < QUIET_TO);
    if (!rst_n) begin
      offer = 1'b0;
    end else if (!in_valid || in_taken) begin
      offer = 1'b0;
      if (nav_queue.size() != 0 &&
          !(nav_queue[0].drain_first && expected_views.size() != 0) &&
          (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        item = nav_queue.pop_front();
        in_func <= item.func;
        in_page <= item.page;
        offer = 1'b1;
        sent_count++;
      end
    end
    in_valid <= offer;
  end

  // Receiver stall: random, one long hold-off, and a quiet stretch
  always @(negedge clk) begin : drive_out_stall
    logic hold;
    if (!rst_n) begin
      hold = 1'b0;
    end else if (hold_left != 0) begin
      hold = 1'b1;
      hold_left--;
    end else if (!hold_done && recv_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold      = 1'b1;
    end else if (recv_count >= QUIET_FROM && recv_count < QUIET_TO) begin
      hold = 1'b0;
    end else begin
      hold = ($urandom_range(99) < IDLE_PCT);
    end
    out_stall <= hold;
  end

  // Monitor: predict on input accept, compare on output accept, watchdog
  always @(posedge clk) begin : check_results
    history_view_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_views.push_back(step_history(in_func, in_page));
      end
      if (out_valid && !out_stall) begin
        recv_count++;
        if (expected_views.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d unexpected: status %0d page %h valid %0b back %0d fwd %0d",
                     recv_count, out_status, out_current_page, out_current_valid,
                     out_back_depth, out_forward_depth);
          end
        end else begin
          want = expected_views.pop_front();
          if (out_status !== want.status || out_current_page !== want.page ||
              out_current_valid !== want.valid || out_back_depth !== want.back_depth ||
              out_forward_depth !== want.fwd_depth) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d expected: status %0d page %h valid %0b back %0d fwd %0d",
                       recv_count, want.status, want.page, want.valid,
                       want.back_depth, want.fwd_depth);
              $display("result %0d actual:   status %0d page %h valid %0b back %0d fwd %0d",
                       recv_count, out_status, out_current_page, out_current_valid,
                       out_back_depth, out_forward_depth);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[back_forward_history_stacks_top] ERROR");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : run_history
    int  pick;
    bit  deep_done;
    bit  drain_done;
    deep_done  = 1'b0;
    drain_done = 1'b0;

    // Directed: refusals on empty history, extreme pages, full back/forward walk
    queue_item(bfhs_pkg::FUNC_BACK, '0);
    queue_item(bfhs_pkg::FUNC_FWD, '1);
    queue_item(bfhs_pkg::FUNC_RSVD, '0);
    queue_item(bfhs_pkg::FUNC_VISIT, '0);
    queue_item(bfhs_pkg::FUNC_BACK, '1);
    queue_item(bfhs_pkg::FUNC_VISIT, '1);
    queue_item(bfhs_pkg::FUNC_VISIT, PB'(32'hA5A5_A5A5));
    queue_item(bfhs_pkg::FUNC_VISIT, PB'(32'h5A5A_5A5A));
    queue_burst(bfhs_pkg::FUNC_BACK, 4);
    queue_item(bfhs_pkg::FUNC_FWD, '0);
    queue_item(bfhs_pkg::FUNC_RSVD, '1);
    queue_burst(bfhs_pkg::FUNC_FWD, 3);
    queue_item(bfhs_pkg::FUNC_BACK, '0);
    queue_item(bfhs_pkg::FUNC_VISIT, PB'(32'h1234_5678));
    queue_item(bfhs_pkg::FUNC_FWD, '1);
    queue_item(bfhs_pkg::FUNC_RSVD, PB'($urandom()));

    // Random: bursts of well-formed navigation, a deep fill of both stacks, some noise
    while (nav_queue.size() < TOTAL_ITEMS) begin
      if (!deep_done && nav_queue.size() >= DEEP_AT) begin
        deep_done = 1'b1;
        queue_burst(bfhs_pkg::FUNC_VISIT, DEPTH + 7);
        queue_burst(bfhs_pkg::FUNC_BACK, DEPTH + 3);
        queue_burst(bfhs_pkg::FUNC_FWD, DEPTH + 3);
      end
      if (!drain_done && nav_queue.size() >= DRAIN_AT) begin
        drain_done = 1'b1;
        mark_drain = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
        queue_burst(bfhs_pkg::FUNC_VISIT, $urandom_range(6, 1));
      end else if (pick < 50) begin
        queue_burst(bfhs_pkg::FUNC_BACK, $urandom_range(6, 1));
      end else if (pick < 65) begin
        queue_burst(bfhs_pkg::FUNC_FWD, $urandom_range(6, 1));
      end else if (pick < 85) begin
        repeat ($urandom_range(12, 4))
          queue_item(bfhs_pkg::func_t'($urandom_range(2)), PB'($urandom()));
      end else begin
        repeat ($urandom_range(4, 1))
          queue_item(bfhs_pkg::func_t'($urandom_range(3)), PB'($urandom()));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (nav_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("[back_forward_history_stacks_top] OK");
    end else begin
      $display("[back_forward_history_stacks_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/bfhs_pkg.sv
src/bfhs_cell.sv
src/bfhs_stack.sv
src/bfhs_skid.sv
src/back_forward_history_stacks_top.sv
verif/back_forward_history_stacks_top_tb.sv
